### src/collatz_rhythm_clock_multiplier_macros.svh
// ----------------------------------------------------------------------------
// collatz rhythm clock multiplier assertion macros
// property checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef COLLATZ_RHYTHM_CLOCK_MULTIPLIER_MACROS_SVH
`define COLLATZ_RHYTHM_CLOCK_MULTIPLIER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CRCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crcm assertion failed");
// next-cycle implication
`define CRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crcm assertion failed");
`else
`define CRCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/crcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcm_pkg
// types, constants and helpers of the collatz rhythm clock multiplier
// ----------------------------------------------------------------------------
package crcm_pkg;

	localparam int unsigned INITIAL_PERIOD_DEF = 48000;
	localparam int unsigned VALUE_WIDTH_DEF    = 32;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int START_W     = 16;
	localparam int MOD_W       = 7;
	localparam int PHASE_W     = 32;
	localparam int FRAC_W      = 8;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_BITS    = 50;
	localparam int OUT_DATA_W  = 56;

	// divider: dividend bits of a period division, result bits per cycle
	localparam int PER_DIV_BITS   = PHASE_W + FRAC_W;
	localparam int DIV_RADIX_BITS = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_START_NUMBER = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BEAT_MODULUS = 1'd1;

	localparam logic [START_W-1:0] START_NUMBER_RST = 16'd5;
	localparam logic [MOD_W-1:0]   BEAT_MODULUS_RST = 7'd24;

	localparam logic [PHASE_W-1:0] PHASE_STEP = 32'd256;
	localparam logic [PHASE_W-1:0] PHASE_SAT  = 32'hFFFF_FEFF;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MOD  = 7'b0000010,
		ST_QUO  = 7'b0000100,
		ST_AMOD = 7'b0001000,
		ST_BDIV = 7'b0010000,
		ST_ADIV = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               high;
	} train_t;

	// one tick of a 24.8 pulse train with pulse length d
	function automatic train_t train_step(logic [PHASE_W-1:0] phase, logic [PHASE_W-1:0] d);
		train_t r;
		logic [PHASE_W-1:0] p;
		p = (phase > PHASE_SAT) ? '1 : phase + PHASE_STEP;
		r.high = {p, 1'b0} < {1'b0, d};
		r.phase = (p >= d) ? p - d : p;
		return r;
	endfunction

endpackage

### src/collatz_rhythm_clock_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collatz_rhythm_clock_multiplier
// collatz sequence clocked by an external pulse, with beat and accent trains
// ----------------------------------------------------------------------------
// One input beat per sample tick, one result beat per input beat. Each beat
// takes a run of one shared 2-bit-per-cycle restoring divider: value mod
// modulus always, value / beats and that quotient mod modulus when beats is
// nonzero, and the two pulse lengths (period * 256 / count) while a sequence
// runs. The input is not ready during that run, and a finished result may
// wait in the output register while the next beat is taken.
`include "collatz_rhythm_clock_multiplier_macros.svh"

module collatz_rhythm_clock_multiplier #(
	parameter int unsigned INITIAL_PERIOD = crcm_pkg::INITIAL_PERIOD_DEF,
	parameter int unsigned VALUE_WIDTH    = crcm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [crcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [crcm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// clock_level, clock_present, start_level, start_held, reset_level
	input  logic [crcm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// gate, accent, done_res, armed_or_running, current_value, beats, accent_count
	output logic [crcm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import crcm_pkg::*;

	localparam int VW2       = VALUE_WIDTH + (VALUE_WIDTH % 2);
	localparam int DIV_W     = (VW2 > PER_DIV_BITS) ? VW2 : PER_DIV_BITS;
	localparam int VAL_PAD   = DIV_W - VW2;
	localparam int PER_PAD   = DIV_W - PER_DIV_BITS;
	localparam int VAL_STEPS = VW2 / DIV_RADIX_BITS;
	localparam int PER_STEPS = PER_DIV_BITS / DIV_RADIX_BITS;
	localparam int CNT_W     = $clog2(DIV_W / DIV_RADIX_BITS + 1);

	state_t                  state_q, state_d;
	logic [START_W-1:0]      start_number_q;
	logic [MOD_W-1:0]        modulus_q;
	logic [MOD_W-1:0]        m_eff;
	logic                    running_q, running_d;
	logic                    pending_q, pending_d;
	logic                    prev_clk_q, prev_clk_d;
	logic                    prev_start_q, prev_start_d;
	logic                    prev_rst_q, prev_rst_d;
	logic [PHASE_W-1:0]      ticks_q, ticks_d;
	logic [PHASE_W-1:0]      period_q, period_d;
	logic [PHASE_W-1:0]      per_eff;
	logic                    pvalid_q, pvalid_d;
	logic [PHASE_W-1:0]      bphase_q, bphase_d;
	logic [PHASE_W-1:0]      aphase_q, aphase_d;
	logic [1:0]              held_q, held_d;
	logic [VALUE_WIDTH-1:0]  value_q, value_d, value_step;
	logic                    m_tvalid_q, m_tvalid_d;
	logic [CNT_W-1:0]        div_cnt_q, div_cnt_d;

	logic                    present_q, present_d;
	logic [MOD_W-1:0]        beats_q, beats_d;
	logic [MOD_W-1:0]        accents_q, accents_d;
	logic                    gate_hi_q, gate_hi_d;
	logic                    acc_hi_q, acc_hi_d;
	logic [DIV_W-1:0]        div_num_q, div_num_d;
	logic [MOD_W-1:0]        div_rem_q, div_rem_d;
	logic [MOD_W-1:0]        div_den_q, div_den_d;
	logic [OUT_DATA_W-1:0]   m_tdata_q, m_tdata_d;

	logic [DIV_W-1:0]        st_num;
	logic [MOD_W-1:0]        st_rem;
	logic [MOD_W:0]          st_t;
	logic [PHASE_W-1:0]      d_sat;
	train_t                  train;
	logic                    in_clk, in_present, in_start, in_held, in_rst;

	assign in_clk     = s_axis_tdata[0];
	assign in_present = s_axis_tdata[1];
	assign in_start   = s_axis_tdata[2];
	assign in_held    = s_axis_tdata[3];
	assign in_rst     = s_axis_tdata[4];

	assign m_eff      = (modulus_q == '0) ? MOD_W'(1) : modulus_q;
	assign per_eff    = (period_q == '0) ? PHASE_W'(1) : period_q;
	assign value_step = (value_q << 1) + value_q + VALUE_WIDTH'(1);
	assign d_sat      = (|div_num_q[PER_DIV_BITS-1:PHASE_W]) ? '1 : div_num_q[PHASE_W-1:0];
	assign train      = train_step(state_q == ST_BDIV ? bphase_q : aphase_q, d_sat);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// shared divider, two quotient bits per cycle
	always_comb begin
		st_rem = div_rem_q;
		st_num = div_num_q;
		st_t   = '0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			st_t   = {st_rem, st_num[DIV_W-1]};
			st_num = {st_num[DIV_W-2:0], 1'b0};
			if (st_t >= {1'b0, div_den_q}) begin
				st_rem    = MOD_W'(st_t - {1'b0, div_den_q});
				st_num[0] = 1'b1;
			end else begin
				st_rem = st_t[MOD_W-1:0];
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		running_d    = running_q;
		pending_d    = pending_q;
		prev_clk_d   = prev_clk_q;
		prev_start_d = prev_start_q;
		prev_rst_d   = prev_rst_q;
		ticks_d      = ticks_q;
		period_d     = period_q;
		pvalid_d     = pvalid_q;
		bphase_d     = bphase_q;
		aphase_d     = aphase_q;
		held_d       = held_q;
		value_d      = value_q;
		m_tvalid_d   = m_tvalid_q;
		present_d    = present_q;
		beats_d      = beats_q;
		accents_d    = accents_q;
		gate_hi_d    = gate_hi_q;
		acc_hi_d     = acc_hi_q;
		m_tdata_d    = m_tdata_q;
		div_num_d    = div_num_q;
		div_rem_d    = div_rem_q;
		div_den_d    = div_den_q;
		div_cnt_d    = div_cnt_q;

		if (m_tvalid_q && m_axis_tready) begin
			m_tvalid_d = 1'b0;
		end
		if (div_cnt_q != '0) begin
			div_num_d = st_num;
			div_rem_d = st_rem;
			div_cnt_d = div_cnt_q - CNT_W'(1);
		end

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (in_rst && !prev_rst_q) begin
						running_d = 1'b0;
						value_d   = '0;
						held_d    = '0;
					end
					if (((in_start && !prev_start_q) || in_held) && !running_d && !pending_d) begin
						pending_d = 1'b1;
					end
					if (in_present) begin
						if (in_clk && !prev_clk_q) begin
							if (pending_d) begin
								value_d   = VALUE_WIDTH'(start_number_q);
								running_d = 1'b1;
								pending_d = 1'b0;
							end else if (running_d) begin
								if (value_q == '0) begin
									running_d = 1'b0;
								end else if (value_q == VALUE_WIDTH'(1)) begin
									running_d = 1'b0;
									pvalid_d  = 1'b1;
									bphase_d  = '0;
									aphase_d  = '0;
									held_d    = '0;
								end else if (!value_q[0]) begin
									value_d = value_q >> 1;
								end else begin
									value_d = value_step;
								end
							end
							if (pvalid_d) begin
								period_d = ticks_q;
							end
							ticks_d  = '0;
							pvalid_d = 1'b1;
						end
						prev_clk_d = in_clk;
					end
					if (pvalid_d && in_present && ticks_d != '1) begin
						ticks_d = ticks_d + PHASE_W'(1);
					end
					prev_start_d = in_start;
					prev_rst_d   = in_rst;
					present_d    = in_present;
					div_num_d    = DIV_W'(value_d) << VAL_PAD;
					div_rem_d    = '0;
					div_den_d    = m_eff;
					div_cnt_d    = CNT_W'(VAL_STEPS);
					state_d      = ST_MOD;
				end
			end
			ST_MOD: begin
				if (div_cnt_q == '0) begin
					beats_d = div_rem_q;
					if (div_rem_q != '0) begin
						div_num_d = DIV_W'(value_q) << VAL_PAD;
						div_rem_d = '0;
						div_den_d = div_rem_q;
						div_cnt_d = CNT_W'(VAL_STEPS);
						state_d   = ST_QUO;
					end else begin
						accents_d = '0;
						if (running_q) begin
							div_num_d = DIV_W'({per_eff, {FRAC_W{1'b0}}}) << PER_PAD;
							div_rem_d = '0;
							div_den_d = MOD_W'(1);
							div_cnt_d = CNT_W'(PER_STEPS);
							state_d   = ST_BDIV;
						end else begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_QUO: begin
				if (div_cnt_q == '0) begin
					div_num_d = div_num_q << VAL_PAD;
					div_rem_d = '0;
					div_den_d = m_eff;
					div_cnt_d = CNT_W'(VAL_STEPS);
					state_d   = ST_AMOD;
				end
			end
			ST_AMOD: begin
				if (div_cnt_q == '0) begin
					accents_d = div_rem_q;
					if (running_q) begin
						div_num_d = DIV_W'({per_eff, {FRAC_W{1'b0}}}) << PER_PAD;
						div_rem_d = '0;
						div_den_d = beats_q;
						div_cnt_d = CNT_W'(PER_STEPS);
						state_d   = ST_BDIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_BDIV: begin
				if (div_cnt_q == '0) begin
					bphase_d  = train.phase;
					gate_hi_d = train.high;
					div_num_d = DIV_W'({per_eff, {FRAC_W{1'b0}}}) << PER_PAD;
					div_rem_d = '0;
					div_den_d = (accents_q == '0) ? MOD_W'(1) : accents_q;
					div_cnt_d = CNT_W'(PER_STEPS);
					state_d   = ST_ADIV;
				end
			end
			ST_ADIV: begin
				if (div_cnt_q == '0) begin
					aphase_d = train.phase;
					acc_hi_d = train.high;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_axis_tready) begin
					if (running_q) begin
						if (present_q) begin
							held_d = {(accents_q != '0) && acc_hi_q, (beats_q != '0) && gate_hi_q};
						end else begin
							held_d   = '0;
							pvalid_d = 1'b0;
						end
					end
					m_tdata_d = OUT_DATA_W'({accents_q, beats_q, 32'(value_q),
						pending_q || running_q, !running_q, held_d[1], held_d[0]});
					m_tvalid_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_number_q <= START_NUMBER_RST;
			modulus_q      <= BEAT_MODULUS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START_NUMBER: start_number_q <= cfg_wdata[START_W-1:0];
				REG_BEAT_MODULUS: modulus_q      <= cfg_wdata[MOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			running_q    <= 1'b0;
			pending_q    <= 1'b0;
			prev_clk_q   <= 1'b0;
			prev_start_q <= 1'b0;
			prev_rst_q   <= 1'b0;
			ticks_q      <= PHASE_W'(INITIAL_PERIOD);
			period_q     <= PHASE_W'(INITIAL_PERIOD);
			pvalid_q     <= 1'b0;
			bphase_q     <= '0;
			aphase_q     <= '0;
			held_q       <= '0;
			value_q      <= '0;
			m_tvalid_q   <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			state_q      <= state_d;
			running_q    <= running_d;
			pending_q    <= pending_d;
			prev_clk_q   <= prev_clk_d;
			prev_start_q <= prev_start_d;
			prev_rst_q   <= prev_rst_d;
			ticks_q      <= ticks_d;
			period_q     <= period_d;
			pvalid_q     <= pvalid_d;
			bphase_q     <= bphase_d;
			aphase_q     <= aphase_d;
			held_q       <= held_d;
			value_q      <= value_d;
			m_tvalid_q   <= m_tvalid_d;
			div_cnt_q    <= div_cnt_d;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		present_q <= present_d;
		beats_q   <= beats_d;
		accents_q <= accents_d;
		gate_hi_q <= gate_hi_d;
		acc_hi_q  <= acc_hi_d;
		div_num_q <= div_num_d;
		div_rem_q <= div_rem_d;
		div_den_q <= div_den_d;
		m_tdata_q <= m_tdata_d;
	end

	`CRCM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`CRCM_ASSERT_IMPL(a_div_rem_below_den, clk, arst_n, state_q != ST_IDLE && state_q != ST_DONE, div_rem_q < div_den_q && div_den_q != '0)
	`CRCM_ASSERT_NEXT(a_done_hands_over, clk, arst_n, state_q == ST_DONE && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && s_axis_tready)

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the collatz rhythm clock multiplier: every tick beat
// is run through a local copy of the sequencer, period meter and pulse trains,
// and each result beat is compared field by field with the predicted one
// ----------------------------------------------------------------------------
module tb_top;
	import crcm_pkg::*;

	// {reset_level, start_held, start_level, clock_present, clock_level}
	typedef struct packed {
		logic reset_level;
		logic start_held;
		logic start_level;
		logic clock_present;
		logic clock_level;
	} tick_in_t;

	typedef struct packed {
		logic [6:0]  accent_count;
		logic [6:0]  beats;
		logic [31:0] current_value;
		logic        armed_or_running;
		logic        done_res;
		logic        accent;
		logic        gate;
	} tick_out_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_START_NUMBER;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// clock_level, clock_present, start_level, start_held, reset_level
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// gate, accent, done_res, armed_or_running, current_value, beats, accent_count
	logic [OUT_DATA_W-1:0]  m_axis_tdata;

	collatz_rhythm_clock_multiplier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tick_out_t expected_ticks[$];
	int        error_count = 0;
	int        ticks_sent = 0;
	bit        src_idle = 1'b1;
	bit        sink_idle = 1'b1;
	tick_in_t  lv = '0;

	// sequencer copy
	logic [START_W-1:0] cfg_start;
	logic [MOD_W-1:0]   cfg_modulus;
	logic [31:0]        seq_value;
	bit                 seq_running, seq_armed;
	bit                 prev_clk, prev_start, prev_rst;
	logic [31:0]        ticks_count, period_ticks;
	bit                 period_ok;
	logic [31:0]        gate_phase, acc_phase;
	bit                 gate_hold, acc_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit pulse_step(inout logic [31:0] phase, input logic [6:0] count);
		logic [63:0] n, per, d;
		bit high;
		n = (count == 0) ? 64'd1 : {57'd0, count};
		per = (period_ticks == 0) ? 64'd1 : {32'd0, period_ticks};
		d = (per << 8) / n;
		if (d > 64'hFFFF_FFFF)
			d = 64'hFFFF_FFFF;
		phase = (phase > 32'hFFFF_FEFF) ? 32'hFFFF_FFFF : phase + 32'd256;
		high = ({32'd0, phase} << 1) < d;
		if ({32'd0, phase} >= d)
			phase = phase - d[31:0];
		return high;
	endfunction

	function automatic tick_out_t predict_tick(tick_in_t t);
		tick_out_t r;
		logic [31:0] m, nb, na;
		bit g, a;
		m = (cfg_modulus == 0) ? 32'd1 : {25'd0, cfg_modulus};
		if (t.reset_level && !prev_rst) begin
			seq_running = 1'b0;
			seq_value = '0;
			gate_hold = 1'b0;
			acc_hold = 1'b0;
		end
		if (((t.start_level && !prev_start) || t.start_held) && !seq_running && !seq_armed)
			seq_armed = 1'b1;
		if (t.clock_present) begin
			if (t.clock_level && !prev_clk) begin
				if (seq_armed) begin
					seq_value = {16'd0, cfg_start};
					seq_running = 1'b1;
					seq_armed = 1'b0;
				end else if (seq_running) begin
					if (seq_value == 0) begin
						seq_running = 1'b0;
					end else if (seq_value == 1) begin
						seq_running = 1'b0;
						period_ok = 1'b1;
						gate_phase = '0;
						acc_phase = '0;
						gate_hold = 1'b0;
						acc_hold = 1'b0;
					end else if (!seq_value[0]) begin
						seq_value = seq_value >> 1;
					end else begin
						seq_value = 32'd3 * seq_value + 32'd1;
					end
				end
				if (period_ok)
					period_ticks = ticks_count;
				ticks_count = '0;
				period_ok = 1'b1;
			end
			prev_clk = t.clock_level;
		end
		if (period_ok && t.clock_present && ticks_count != 32'hFFFF_FFFF)
			ticks_count = ticks_count + 1;
		nb = seq_value % m;
		na = (nb != 0) ? (seq_value / nb) % m : 32'd0;
		if (seq_running) begin
			g = pulse_step(gate_phase, nb[6:0]);
			a = pulse_step(acc_phase, na[6:0]);
			if (t.clock_present) begin
				gate_hold = (nb >= 1) && g;
				acc_hold = (na >= 1) && a;
			end else begin
				gate_hold = 1'b0;
				acc_hold = 1'b0;
				period_ok = 1'b0;
			end
		end
		prev_start = t.start_level;
		prev_rst = t.reset_level;
		r.gate = gate_hold;
		r.accent = acc_hold;
		r.done_res = !seq_running;
		r.armed_or_running = seq_armed || seq_running;
		r.current_value = seq_value;
		r.beats = nb[6:0];
		r.accent_count = na[6:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// result side: random stalls, one check per beat
	initial begin
		int stall;
		tick_out_t got, want;
		forever begin
			stall = sink_idle ? $urandom_range(0, 10) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = m_axis_tdata[OUT_BITS-1:0];
			if (expected_ticks.size() == 0) begin
				$error("result beat with no expected result, data %h", got);
				error_count++;
			end else begin
				want = expected_ticks.pop_front();
				check_field("gate", 32'(want.gate), 32'(got.gate));
				check_field("accent", 32'(want.accent), 32'(got.accent));
				check_field("done_res", 32'(want.done_res), 32'(got.done_res));
				check_field("armed_or_running", 32'(want.armed_or_running),
					32'(got.armed_or_running));
				check_field("current_value", want.current_value, got.current_value);
				check_field("beats", 32'(want.beats), 32'(got.beats));
				check_field("accent_count", 32'(want.accent_count), 32'(got.accent_count));
			end
		end
	end

	task automatic send_tick(input tick_in_t t);
		int gap;
		gap = src_idle ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'(t);
		do @(posedge clk); while (!s_axis_tready);
		expected_ticks.push_back(predict_tick(t));
		ticks_sent++;
	endtask

	// wait for every result, then let the divider run dry
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_START_NUMBER)
			cfg_start = data;
		else
			cfg_modulus = data[MOD_W-1:0];
	endtask

	task automatic set_config(input logic [15:0] start_val, input logic [15:0] modulus);
		settle();
		write_reg(REG_START_NUMBER, start_val);
		write_reg(REG_BEAT_MODULUS, modulus);
	endtask

	// one tick of the current levels with occasional dropouts, resets and starts
	task automatic noisy_tick();
		tick_in_t t;
		t = lv;
		t.clock_present = ($urandom_range(0, 19) != 0);
		t.reset_level = ($urandom_range(0, 99) == 0);
		t.start_level = ($urandom_range(0, 29) == 0);
		t.start_held = ($urandom_range(0, 49) == 0);
		send_tick(t);
	endtask

	// arm a start, then clock until the sequence ends or the cap is hit
	task automatic run_sequence(input int cap);
		int hi, lo, n, hold;
		lv = '0;
		lv.clock_present = 1'b1;
		send_tick(lv);
		if ($urandom_range(0, 1)) begin
			lv.start_level = 1'b1;
			send_tick(lv);
			lv.start_level = 1'b0;
		end else begin
			hold = $urandom_range(1, 3);
			lv.start_held = 1'b1;
			repeat (hold) send_tick(lv);
			lv.start_held = 1'b0;
		end
		n = 0;
		hi = $urandom_range(1, 4);
		lo = $urandom_range(1, 4);
		while ((seq_running || seq_armed) && n < cap) begin
			if ($urandom_range(0, 7) == 0) begin
				hi = $urandom_range(1, 6);
				lo = $urandom_range(1, 6);
			end
			lv.clock_level = 1'b1;
			for (int i = 0; i < hi; i++) begin
				noisy_tick();
				n++;
			end
			lv.clock_level = 1'b0;
			for (int i = 0; i < lo; i++) begin
				noisy_tick();
				n++;
			end
		end
		if (seq_running) begin
			lv.reset_level = 1'b1;
			send_tick(lv);
			lv.reset_level = 1'b0;
			send_tick(lv);
		end
	endtask

	task automatic test_directed();
		// order of the literals: reset, held, start, present, clock
		send_tick(5'b00000);
		send_tick(5'b00011);
		send_tick(5'b00010);
		send_tick(5'b00110);
		send_tick(5'b00111);
		send_tick(5'b00010);
		send_tick(5'b00011);
		// clock absent while running, then a high level that is not an edge
		send_tick(5'b00000);
		send_tick(5'b00001);
		send_tick(5'b00011);
		send_tick(5'b00010);
		send_tick(5'b10010);
		// held start while reset stays high
		send_tick(5'b11010);
		send_tick(5'b11011);
		send_tick(5'b11111);
		send_tick(5'b00000);
		send_tick(5'b10010);
		// zero modulus and completion at one
		set_config(16'd1, 16'd0);
		send_tick(5'b01010);
		send_tick(5'b00011);
		send_tick(5'b00010);
		send_tick(5'b00011);
		send_tick(5'b00010);
		// zero start value stops on the next clock
		set_config(16'd0, 16'd24);
		send_tick(5'b00110);
		send_tick(5'b00111);
		send_tick(5'b00010);
		send_tick(5'b00011);
	endtask

	task automatic test_register_extremes();
		set_config(16'hFFFF, 16'd127);
		run_sequence(60);
		set_config(16'hFFFF, 16'd100);
		run_sequence(40);
		set_config(16'd27, 16'd1);
		run_sequence(40);
		set_config(16'd3, 16'd101);
		run_sequence(80);
		set_config(16'd0, 16'd0);
		run_sequence(20);
	endtask

	task automatic test_random_sequences(input int target);
		logic [15:0] sv, mv;
		while (ticks_sent < target) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: sv = 16'($urandom_range(0, 3));
					1: sv = 16'($urandom_range(0, 65535));
					default: sv = 16'($urandom_range(1, 60));
				endcase
				case ($urandom_range(0, 5))
					0: mv = 16'($urandom_range(0, 2));
					1: mv = 16'($urandom_range(101, 127));
					2: mv = 16'd100;
					default: mv = 16'($urandom_range(1, 30));
				endcase
				set_config(sv, mv);
			end
			run_sequence($urandom_range(40, 150));
		end
	endtask

	task automatic test_line_noise(input int count);
		tick_in_t t;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (count) begin
			t = 5'($urandom_range(0, 31));
			send_tick(t);
		end
	endtask

	initial begin
		cfg_start = START_NUMBER_RST;
		cfg_modulus = BEAT_MODULUS_RST;
		seq_value = '0;
		seq_running = 1'b0;
		seq_armed = 1'b0;
		prev_clk = 1'b0;
		prev_start = 1'b0;
		prev_rst = 1'b0;
		ticks_count = INITIAL_PERIOD_DEF;
		period_ticks = INITIAL_PERIOD_DEF;
		period_ok = 1'b0;
		gate_phase = '0;
		acc_phase = '0;
		gate_hold = 1'b0;
		acc_hold = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_extremes();
		test_random_sequences(1100);
		test_line_noise(150);
		settle();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
